// ===== src/lfu_pkg.sv =====
// Package for the LFU page replacement unit: sizes, register map,
// sequencer state codes. Used by the interfaces and the top level.
// No dependencies.
package lfu_pkg;

  localparam int FRAMES     = 8;
  localparam int PAGE_BITS  = 16;
  localparam int COUNT_BITS = 16;
  localparam int FIDX_W     = $clog2(FRAMES);
  localparam int FCNT_W     = $clog2(FRAMES + 1);

  // APB register map
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] CFG_ADDR_FRAMES = 2'd0;
  localparam int CFG_FRAMES_W = 4;
  localparam logic [CFG_FRAMES_W-1:0] CFG_FRAMES_RST = 4'd8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef logic [PAGE_BITS-1:0]  page_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [FIDX_W-1:0]     fidx_t;
  typedef logic [FCNT_W-1:0]     fcnt_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

// ===== src/lfu_in_if.sv =====
// Page reference channel: valid/ready handshake with one page number a beat.
// Depends on lfu_pkg.
interface lfu_in_if;
  logic             valid;
  logic             ready;
  lfu_pkg::page_t   page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

// ===== src/lfu_out_if.sv =====
// Result channel: hit flag, frame used and evicted page, one result a beat.
// Depends on lfu_pkg.
interface lfu_out_if;
  logic             valid;
  logic             ready;
  logic             hit;
  lfu_pkg::fidx_t   frame_index;
  logic             evicted_valid;
  lfu_pkg::page_t   evicted_page;

  modport source (output valid, output hit, output frame_index,
                  output evicted_valid, output evicted_page, input ready);
  modport sink   (input valid, input hit, input frame_index,
                  input evicted_valid, input evicted_page, output ready);
endinterface

// ===== src/lfu_page_replacement_unit.sv =====
// LFU page replacement unit: frame table, scan sequencer, APB register.
// Depends on lfu_pkg, lfu_in_if and lfu_out_if.
//
// Usage:
//   in_chan carries one page reference a beat; out_chan returns one result
//   a beat: hit, frame_index, evicted_valid and evicted_page.
//   The APB port holds frames_in_use at address 0 (0 acts as 1, values
//   above 8 act as 8). Write it only while the unit is idle.
// Timing:
//   After a reference is taken, one compare unit walks the active frames,
//   one frame a cycle, checking for a match and tracking the lowest count.
//   The DONE state then updates the table and loads the result register,
//   waiting while the result register is still full. The unit takes no
//   new reference until the update is done and it is back in IDLE, so
//   the scan of the N active frames (frames_in_use after clamping) sets
//   the pace.
// Reset:
//   rst_n is synchronous, active low. It clears all valid marks, the fill
//   count and the result valid flag, and sets frames_in_use to 8.
// Stalls:
//   The result register holds while out_chan.ready is low. The next
//   reference may be taken and scanned meanwhile; the table update waits
//   until the result register is free.
module lfu_page_replacement_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  lfu_in_if.sink                        in_chan,
  lfu_out_if.source                     out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfu_pkg::PADDR_W-1:0]   paddr,
  input  logic [lfu_pkg::PDATA_W-1:0]   pwdata,
  output logic [lfu_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import lfu_pkg::*;

  // Configuration register
  logic [CFG_FRAMES_W-1:0] frames_in_use_r;
  logic                    cfg_wr;

  // Frame table
  page_t  frame_page_r  [FRAMES];
  count_t use_count_r   [FRAMES];
  logic   [FRAMES-1:0]  frame_valid_r;
  fcnt_t  filled_r;

  // Sequencer and scan state
  state_t state_r, state_nxt;
  page_t  page_r;
  fidx_t  idx_r;
  logic   found_r;
  fidx_t  hit_idx_r;
  count_t hit_cnt_r;
  fidx_t  min_idx_r;
  count_t min_cnt_r;
  page_t  min_page_r;
  logic   min_vld_r;

  // Result register
  logic   out_valid_r;
  logic   out_hit_r;
  fidx_t  out_idx_r;
  logic   out_ev_valid_r;
  page_t  out_ev_page_r;

  fcnt_t  active_n;
  fidx_t  last_idx;
  logic   in_beat;
  logic   out_free;
  logic   commit;

  page_t  rd_page;
  logic   rd_vld;
  count_t rd_cnt;
  logic   match;
  logic   less;

  // Clamp the frame count to 1..FRAMES
  always_comb begin
    if (frames_in_use_r == '0) begin
      active_n = fcnt_t'(1);
    end else if (frames_in_use_r > CFG_FRAMES_W'(FRAMES)) begin
      active_n = fcnt_t'(FRAMES);
    end else begin
      active_n = fcnt_t'(frames_in_use_r);
    end
  end
  assign last_idx = fidx_t'(active_n - fcnt_t'(1));

  // APB access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == CFG_ADDR_FRAMES);
  assign prdata = (paddr == CFG_ADDR_FRAMES) ?
                  PDATA_W'(frames_in_use_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= CFG_FRAMES_RST;
    end else if (cfg_wr) begin
      frames_in_use_r <= pwdata[CFG_FRAMES_W-1:0];
    end
  end

  // Handshakes
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_beat       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign commit        = (state_r == ST_DONE) && out_free;

  // Shared compare unit: one frame per cycle
  assign rd_vld  = frame_valid_r[idx_r];
  assign rd_page = rd_vld ? frame_page_r[idx_r] : '0;
  assign rd_cnt  = rd_vld ? use_count_r[idx_r]  : '0;
  assign match   = rd_vld && (rd_page == page_r) && !found_r;
  assign less    = (idx_r == '0) || (rd_cnt < min_cnt_r);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx_r == last_idx) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Scan registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      page_r  <= in_chan.page;
      idx_r   <= '0;
      found_r <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      if (match) begin
        found_r   <= 1'b1;
        hit_idx_r <= idx_r;
        hit_cnt_r <= rd_cnt;
      end
      if (less) begin
        min_idx_r  <= idx_r;
        min_cnt_r  <= rd_cnt;
        min_page_r <= rd_page;
        min_vld_r  <= rd_vld;
      end
      if (idx_r != last_idx) idx_r <= idx_r + fidx_t'(1);
    end
  end

  // Table update: bump on hit, fill a free frame, or replace the minimum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= '0;
      filled_r      <= '0;
    end else if (commit) begin
      if (found_r) begin
        if (hit_cnt_r != COUNT_MAX) use_count_r[hit_idx_r] <= hit_cnt_r + count_t'(1);
      end else if (filled_r < active_n) begin
        frame_page_r[filled_r[FIDX_W-1:0]]  <= page_r;
        use_count_r[filled_r[FIDX_W-1:0]]   <= count_t'(1);
        frame_valid_r[filled_r[FIDX_W-1:0]] <= 1'b1;
        filled_r <= filled_r + fcnt_t'(1);
      end else begin
        frame_page_r[min_idx_r]  <= page_r;
        use_count_r[min_idx_r]   <= count_t'(1);
        frame_valid_r[min_idx_r] <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit_r <= found_r;
      if (found_r) begin
        out_idx_r      <= hit_idx_r;
        out_ev_valid_r <= 1'b0;
        out_ev_page_r  <= '0;
      end else if (filled_r < active_n) begin
        out_idx_r      <= filled_r[FIDX_W-1:0];
        out_ev_valid_r <= 1'b0;
        out_ev_page_r  <= '0;
      end else begin
        out_idx_r      <= min_idx_r;
        out_ev_valid_r <= min_vld_r;
        out_ev_page_r  <= min_vld_r ? min_page_r : '0;
      end
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.hit           = out_hit_r;
  assign out_chan.frame_index   = out_idx_r;
  assign out_chan.evicted_valid = out_ev_valid_r;
  assign out_chan.evicted_page  = out_ev_page_r;

  // Checks
  a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= fcnt_t'(FRAMES))
    else $error("fill count beyond frame table");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_hit_r |-> !out_ev_valid_r)
    else $error("hit result reports an eviction");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> fcnt_t'(idx_r) < active_n)
    else $error("scan index beyond active frames");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> state_r == ST_SCAN && idx_r == '0)
    else $error("accepted reference did not start a scan");

  a_commit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r && state_r == ST_IDLE)
    else $error("table update did not load the result register");

endmodule
